// File: hdl/cppt_pkg.sv
// ----------------------------------------------------------------------------
// cppt_pkg
// Shared constants and types for the cascaded peak / PEP / average tracker.
// ----------------------------------------------------------------------------
package cppt_pkg;

  // Default ring depths.
  localparam int SHORT_DEPTH_DEF     = 16;
  localparam int PEP_DEPTH_DEF       = 64;
  localparam int LONG_DEPTH_DEF      = 32;
  localparam int AVG_SHORT_DEPTH_DEF = 16;
  localparam int AVG_LONG_DEPTH_DEF  = 128;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int PEP_LEN_W  = 7;
  localparam int LONG_LEN_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PEP_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LENGTH = 1'b1;

  localparam logic [PEP_LEN_W-1:0]  PEP_LEN_RST  = 7'd10;
  localparam logic [LONG_LEN_W-1:0] LONG_LEN_RST = 6'd32;

  // Classified request handed from the front end to the back end.
  // Index and length fields are sized for the largest depth allowed.
  typedef struct packed {
    logic [31:0]        uw;
    logic signed [15:0] cdb;
    logic [7:0]         sidx;   // short ring write slot
    logic               sfull;  // short ring has wrapped before
    logic               swrap;  // this request wraps the short ring
    logic [8:0]         plen;   // clamped PEP window length
    logic [8:0]         llen;   // clamped long window length
  } item_t;

endpackage

// File: hdl/cppt_fifo.sv
// ----------------------------------------------------------------------------
// cppt_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cppt_fifo
  import cppt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: hdl/cppt_front.sv
// ----------------------------------------------------------------------------
// cppt_front
// Accepts samples, holds the configuration registers and tags each request
// with its short ring slot and the clamped window lengths.
// ----------------------------------------------------------------------------
module cppt_front
  import cppt_pkg::*;
#(
  parameter int SHORT_DEPTH = SHORT_DEPTH_DEF,
  parameter int PEP_DEPTH   = PEP_DEPTH_DEF,
  parameter int LONG_DEPTH  = LONG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [31:0]           in_power_uw,
  input  logic signed [15:0]    in_power_cdb,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  q_push,
  output item_t                 q_item,
  input  logic                  q_full
);

  localparam int SAW = $clog2(SHORT_DEPTH);

  logic [PEP_LEN_W-1:0]  pep_len_r;
  logic [LONG_LEN_W-1:0] long_len_r;
  logic [SAW-1:0]        short_pos_r;
  logic                  short_full_r;
  logic                  accept;
  logic                  swrap;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;
  assign swrap   = (short_pos_r == SAW'(SHORT_DEPTH - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pep_len_r  <= PEP_LEN_RST;
      long_len_r <= LONG_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PEP_LENGTH:  pep_len_r  <= cfg_data[PEP_LEN_W-1:0];
        REG_LONG_LENGTH: long_len_r <= cfg_data[LONG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Short ring slot tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_pos_r  <= '0;
      short_full_r <= 1'b0;
    end else if (accept) begin
      short_pos_r <= swrap ? '0 : short_pos_r + SAW'(1);
      if (swrap) begin
        short_full_r <= 1'b1;
      end
    end
  end

  // Build the request, clamping the window lengths to their legal range.
  always_comb begin
    q_item       = '0;
    q_item.uw    = in_power_uw;
    q_item.cdb   = in_power_cdb;
    q_item.sidx  = 8'(short_pos_r);
    q_item.sfull = short_full_r;
    q_item.swrap = swrap;
    if (pep_len_r == '0) begin
      q_item.plen = 9'd1;
    end else if ({2'b00, pep_len_r} > 9'(PEP_DEPTH)) begin
      q_item.plen = 9'(PEP_DEPTH);
    end else begin
      q_item.plen = {2'b00, pep_len_r};
    end
    if (long_len_r == '0) begin
      q_item.llen = 9'd1;
    end else if ({3'b000, long_len_r} > 9'(LONG_DEPTH)) begin
      q_item.llen = 9'(LONG_DEPTH);
    end else begin
      q_item.llen = {3'b000, long_len_r};
    end
  end

endmodule

// File: hdl/cppt_div.sv
// ----------------------------------------------------------------------------
// cppt_div
// Divider by a fixed divisor that folds the high digit into the low one
// instead of working out one quotient bit at a time.
// ----------------------------------------------------------------------------
module cppt_div #(
  parameter int W       = 36,
  parameter int DIVISOR = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic         busy,
  output logic [31:0]  quot
);

  // With 2^K = DIVISOR + E, x = hi * 2^K + lo = hi * DIVISOR + (hi * E + lo).
  localparam int K = $clog2(DIVISOR + 1);
  localparam int E = (1 << K) - DIVISOR;

  logic [W-1:0]   x_r;
  logic [31:0]    quot_r;
  logic           busy_r;
  logic [W-K-1:0] hi;
  logic [K-1:0]   lo;
  logic [W-1:0]   fold;

  assign busy = busy_r;
  assign quot = quot_r;
  assign hi   = x_r[W-1:K];
  assign lo   = x_r[K-1:0];
  assign fold = W'(hi) * W'(E) + W'(lo);

  // Control: done once the remainder fits in the low digit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (hi == '0)) begin
      busy_r <= 1'b0;
    end
  end

  // Datapath: fold the high digit, then one final compare and subtract.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= dividend;
      quot_r <= '0;
    end else if (busy_r) begin
      if (hi != '0) begin
        x_r    <= fold;
        quot_r <= quot_r + 32'(hi);
      end else if (x_r >= W'(DIVISOR)) begin
        x_r    <= x_r - W'(DIVISOR);
        quot_r <= quot_r + 32'd1;
      end
    end
  end

endmodule

// File: hdl/cppt_back.sv
// ----------------------------------------------------------------------------
// cppt_back
// Executes one request at a time: ring writes, window maximum scans, the
// two moving sums and their dividers, and the result register.
// ----------------------------------------------------------------------------
module cppt_back
  import cppt_pkg::*;
#(
  parameter int SHORT_DEPTH     = SHORT_DEPTH_DEF,
  parameter int PEP_DEPTH       = PEP_DEPTH_DEF,
  parameter int LONG_DEPTH      = LONG_DEPTH_DEF,
  parameter int AVG_SHORT_DEPTH = AVG_SHORT_DEPTH_DEF,
  parameter int AVG_LONG_DEPTH  = AVG_LONG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  item_t              q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_peak_cdb,
  output logic signed [15:0] out_pep_cdb,
  output logic signed [15:0] out_long_cdb,
  output logic [31:0]        out_avg_short_uw,
  output logic [31:0]        out_avg_long_uw
);

  localparam int SAW  = $clog2(SHORT_DEPTH);
  localparam int PAW  = $clog2(PEP_DEPTH);
  localparam int LAW  = $clog2(LONG_DEPTH);
  localparam int PLW  = $clog2(PEP_DEPTH + 1);
  localparam int LLW  = $clog2(LONG_DEPTH + 1);
  localparam int ASAW = $clog2(AVG_SHORT_DEPTH);
  localparam int ALAW = $clog2(AVG_LONG_DEPTH);
  localparam int ASW  = 32 + $clog2(AVG_SHORT_DEPTH);
  localparam int ALW  = 32 + $clog2(AVG_LONG_DEPTH);
  localparam int MAXL0 = (SHORT_DEPTH > PEP_DEPTH) ? SHORT_DEPTH : PEP_DEPTH;
  localparam int MAXL  = (MAXL0 > LONG_DEPTH) ? MAXL0 : LONG_DEPTH;
  localparam int CW    = $clog2(MAXL + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WR    = 9'b000000010,
    S_SUB   = 9'b000000100,
    S_SSCAN = 9'b000001000,
    S_PWR   = 9'b000010000,
    S_PSCAN = 9'b000100000,
    S_LWR   = 9'b001000000,
    S_LSCAN = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  item_t  it_r;

  // Ring storage.
  logic signed [15:0] short_mem [SHORT_DEPTH];
  logic signed [15:0] pep_mem   [PEP_DEPTH];
  logic signed [15:0] long_mem  [LONG_DEPTH];
  logic [31:0]        as_mem    [AVG_SHORT_DEPTH];
  logic [31:0]        al_mem    [AVG_LONG_DEPTH];
  logic signed [15:0] sm_rd_r, pm_rd_r, lm_rd_r;
  logic [31:0]        as_rd_r, al_rd_r;
  logic [PEP_DEPTH-1:0]  pv_r;
  logic [LONG_DEPTH-1:0] lv_r;

  // Positions and holds.
  logic [PAW-1:0]     pep_pos_r;
  logic [LAW-1:0]     long_pos_r;
  logic               pwrap_r;
  logic signed [15:0] peak_r, pep_hold_r, long_hold_r;
  logic [PLW-1:0]     pep_np;
  logic [LLW-1:0]     long_np;
  logic               pep_wrap, long_wrap;

  // Moving sums.
  logic [ASAW-1:0] as_pos_r, as_npos;
  logic [ALAW-1:0] al_pos_r, al_npos;
  logic            as_full_r, al_full_r, as_sv_r, al_sv_r;
  logic [ASW-1:0]  as_sum_r, as_sum_nxt;
  logic [ALW-1:0]  al_sum_r, al_sum_nxt;
  logic            div_start, as_busy, al_busy;
  logic [31:0]     as_quot, al_quot;

  // Window scan.
  logic [CW-1:0]      cnt_r, addr_d_r, scan_len;
  logic               pend_r, scan_on, scan_done;
  logic signed [15:0] max_r, max_nxt, sval;

  // Result register.
  logic        ovalid_r, load_out;
  logic signed [15:0] pep_fin, long_fin;

  assign out_empty = !ovalid_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = (state_r == S_SUB);
  assign load_out  = (state_r == S_DONE) && !as_busy && !al_busy &&
                     (!ovalid_r || out_pop);

  // Ring position arithmetic.
  assign pep_np    = PLW'(pep_pos_r) + PLW'(1);
  assign pep_wrap  = (pep_np >= PLW'(it_r.plen));
  assign long_np   = LLW'(long_pos_r) + LLW'(1);
  assign long_wrap = (long_np >= LLW'(it_r.llen));
  assign as_npos   = (as_pos_r == ASAW'(AVG_SHORT_DEPTH - 1)) ? '0 : as_pos_r + ASAW'(1);
  assign al_npos   = (al_pos_r == ALAW'(AVG_LONG_DEPTH - 1)) ? '0 : al_pos_r + ALAW'(1);

  // Remove the oldest sample; an entry never written counts as zero.
  assign as_sum_nxt = as_sum_r - (as_sv_r ? ASW'(as_rd_r) : '0);
  assign al_sum_nxt = al_sum_r - (al_sv_r ? ALW'(al_rd_r) : '0);

  // Scan length and the value arriving from the selected ring.
  always_comb begin
    scan_len = CW'(SHORT_DEPTH);
    sval     = '0;
    case (state_r)
      S_PSCAN: begin
        scan_len = CW'(it_r.plen);
        sval     = pv_r[addr_d_r[PAW-1:0]] ? pm_rd_r : '0;
      end
      S_LSCAN: begin
        scan_len = CW'(it_r.llen);
        sval     = lv_r[addr_d_r[LAW-1:0]] ? lm_rd_r : '0;
      end
      default: begin
        scan_len = CW'(SHORT_DEPTH);
        sval     = (it_r.sfull || addr_d_r[SAW-1:0] <= it_r.sidx[SAW-1:0]) ?
                   sm_rd_r : '0;
      end
    endcase
  end

  assign scan_on   = (state_r == S_SSCAN) || (state_r == S_PSCAN) ||
                     (state_r == S_LSCAN);
  assign scan_done = (cnt_r == scan_len) && !pend_r;
  assign max_nxt   = (pend_r && sval > max_r) ? sval : max_r;

  // Final holds, raised to the newer maxima.
  assign pep_fin  = (pep_hold_r < peak_r) ? peak_r : pep_hold_r;
  assign long_fin = (long_hold_r < pep_fin) ? pep_fin : long_hold_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_WR;
      S_WR:    state_nxt = S_SUB;
      S_SUB:   state_nxt = S_SSCAN;
      S_SSCAN: if (scan_done) state_nxt = it_r.swrap ? S_PWR : S_DONE;
      S_PWR:   state_nxt = S_PSCAN;
      S_PSCAN: if (scan_done) state_nxt = pwrap_r ? S_LWR : S_DONE;
      S_LWR:   state_nxt = S_LSCAN;
      S_LSCAN: if (scan_done) state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Short ring.
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      short_mem[it_r.sidx[SAW-1:0]] <= it_r.cdb;
    end
    sm_rd_r <= short_mem[cnt_r[SAW-1:0]];
  end

  // PEP ring.
  always_ff @(posedge clk) begin
    if (state_r == S_PWR) begin
      pep_mem[pep_pos_r] <= peak_r;
    end
    pm_rd_r <= pep_mem[cnt_r[PAW-1:0]];
  end

  // Long ring.
  always_ff @(posedge clk) begin
    if (state_r == S_LWR) begin
      long_mem[long_pos_r] <= pep_hold_r;
    end
    lm_rd_r <= long_mem[cnt_r[LAW-1:0]];
  end

  // Average rings: write the new sample, read the one that drops out.
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      as_mem[as_pos_r] <= it_r.uw;
      al_mem[al_pos_r] <= it_r.uw;
    end
    as_rd_r <= as_mem[as_npos];
    al_rd_r <= al_mem[al_npos];
  end

  // Request capture, scan engine and peak register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_item;
    end
    if (scan_on) begin
      if (cnt_r < scan_len) begin
        cnt_r    <= cnt_r + CW'(1);
        addr_d_r <= cnt_r;
        pend_r   <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      max_r <= max_nxt;
    end else begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      max_r  <= 16'sh8000;
    end
    if (state_r == S_SSCAN && scan_done) begin
      peak_r <= max_r;
    end
    if (load_out) begin
      out_peak_cdb     <= peak_r;
      out_pep_cdb      <= pep_fin;
      out_long_cdb     <= long_fin;
      out_avg_short_uw <= as_quot;
      out_avg_long_uw  <= al_quot;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ovalid_r    <= 1'b0;
      pv_r        <= '0;
      lv_r        <= '0;
      pep_pos_r   <= '0;
      long_pos_r  <= '0;
      pwrap_r     <= 1'b0;
      pep_hold_r  <= '0;
      long_hold_r <= '0;
      as_pos_r    <= '0;
      al_pos_r    <= '0;
      as_full_r   <= 1'b0;
      al_full_r   <= 1'b0;
      as_sv_r     <= 1'b0;
      al_sv_r     <= 1'b0;
      as_sum_r    <= '0;
      al_sum_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Result register handshake.
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end

      // Moving sums: add the new sample, then drop the oldest.
      if (state_r == S_WR) begin
        as_sum_r  <= as_sum_r + ASW'(it_r.uw);
        al_sum_r  <= al_sum_r + ALW'(it_r.uw);
        as_pos_r  <= as_npos;
        al_pos_r  <= al_npos;
        as_sv_r   <= as_full_r || (as_npos == '0);
        al_sv_r   <= al_full_r || (al_npos == '0);
        as_full_r <= as_full_r || (as_npos == '0);
        al_full_r <= al_full_r || (al_npos == '0);
      end
      if (state_r == S_SUB) begin
        as_sum_r <= as_sum_nxt;
        al_sum_r <= al_sum_nxt;
      end

      // PEP ring update.
      if (state_r == S_PWR) begin
        pv_r[pep_pos_r] <= 1'b1;
        pep_pos_r       <= pep_wrap ? '0 : PAW'(pep_np);
        pwrap_r         <= pep_wrap;
      end
      if (state_r == S_PSCAN && scan_done) begin
        pep_hold_r <= (max_r < peak_r) ? peak_r : max_r;
      end

      // Long ring update.
      if (state_r == S_LWR) begin
        lv_r[long_pos_r] <= 1'b1;
        long_pos_r       <= long_wrap ? '0 : LAW'(long_np);
      end
      if (state_r == S_LSCAN && scan_done) begin
        long_hold_r <= max_r;
      end

      // Holds are raised as the result is issued.
      if (load_out) begin
        pep_hold_r  <= pep_fin;
        long_hold_r <= long_fin;
      end
    end
  end

  // Average dividers.
  cppt_div #(.W(ASW), .DIVISOR(AVG_SHORT_DEPTH - 1)) u_div_short (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(as_sum_nxt),
    .busy(as_busy), .quot(as_quot)
  );

  cppt_div #(.W(ALW), .DIVISOR(AVG_LONG_DEPTH - 1)) u_div_long (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(al_sum_nxt),
    .busy(al_busy), .quot(al_quot)
  );

endmodule

// File: hdl/cascaded_peak_pep_average_tracker_unit.sv
// ----------------------------------------------------------------------------
// cascaded_peak_pep_average_tracker_unit
// Power meter: short-window peak, PEP and long maximum in centi-dBm, plus
// short and long moving averages in microwatts.
// ----------------------------------------------------------------------------
// One sample goes in, one result comes out. Samples are handled one at a
// time by a sequencer that scans the rings through their memory read ports:
// it takes the request, writes the short and average rings, drops the
// oldest average sample and scans the short ring; a sample that closes a
// short window then writes and scans the PEP ring, and one that also
// closes a PEP window then writes and scans the long ring, before the
// result is loaded. The average dividers start before the short scan and
// run under it with the default depths. A full output register holds the
// sequencer. A two-entry queue in front and an output register behind let
// the input and result sides stall independently. Write the length
// registers only while the block is idle.
module cascaded_peak_pep_average_tracker_unit
  import cppt_pkg::*;
#(
  parameter int SHORT_DEPTH     = SHORT_DEPTH_DEF,
  parameter int PEP_DEPTH       = PEP_DEPTH_DEF,
  parameter int LONG_DEPTH      = LONG_DEPTH_DEF,
  parameter int AVG_SHORT_DEPTH = AVG_SHORT_DEPTH_DEF,
  parameter int AVG_LONG_DEPTH  = AVG_LONG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [31:0]           in_power_uw,
  input  logic signed [15:0]    in_power_cdb,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [15:0]    out_peak_cdb,
  output logic signed [15:0]    out_pep_cdb,
  output logic signed [15:0]    out_long_cdb,
  output logic [31:0]           out_avg_short_uw,
  output logic [31:0]           out_avg_long_uw,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  f_push, f_full, q_pop, q_empty;
  item_t f_item, q_item;

  // Front end: configuration and request tagging.
  cppt_front #(
    .SHORT_DEPTH(SHORT_DEPTH), .PEP_DEPTH(PEP_DEPTH), .LONG_DEPTH(LONG_DEPTH)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_power_uw(in_power_uw), .in_power_cdb(in_power_cdb),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .q_push(f_push), .q_item(f_item), .q_full(f_full)
  );

  // Request queue.
  cppt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(f_push), .din(f_item), .full(f_full),
    .pop(q_pop), .dout(q_item), .empty(q_empty)
  );

  // Back end: rings, scans, averages and result register.
  cppt_back #(
    .SHORT_DEPTH(SHORT_DEPTH), .PEP_DEPTH(PEP_DEPTH), .LONG_DEPTH(LONG_DEPTH),
    .AVG_SHORT_DEPTH(AVG_SHORT_DEPTH), .AVG_LONG_DEPTH(AVG_LONG_DEPTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_item(q_item), .q_empty(q_empty), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_peak_cdb(out_peak_cdb), .out_pep_cdb(out_pep_cdb),
    .out_long_cdb(out_long_cdb),
    .out_avg_short_uw(out_avg_short_uw), .out_avg_long_uw(out_avg_long_uw)
  );

endmodule

// File: hdl/cppt_checker.sv
// ----------------------------------------------------------------------------
// cppt_checker
// Port-level checks for the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module cppt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_empty,
  input logic                  out_pop,
  input logic signed [15:0]    out_peak_cdb,
  input logic signed [15:0]    out_pep_cdb,
  input logic signed [15:0]    out_long_cdb,
  input logic [31:0]           out_avg_short_uw,
  input logic [31:0]           out_avg_long_uw
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // PEP never drops below the short peak.
  a_pep_ge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_pep_cdb >= out_peak_cdb)
    else $error("pep below peak");

  // The long maximum never drops below PEP.
  a_long_ge_pep: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_long_cdb >= out_pep_cdb)
    else $error("long maximum below pep");

  // A waiting result stays shown, and its peak and average fields hold, until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_avg_long_uw) &&
    $stable(out_avg_short_uw) && $stable(out_peak_cdb))
    else $error("waiting result changed");

endmodule

bind cascaded_peak_pep_average_tracker_unit cppt_checker u_cppt_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascaded peak / PEP / long-maximum power meter.
// A predictor inside the bench tracks the rings and the moving sums. Every
// reading the block returns is compared field by field with the oldest
// prediction. Stimulus starts with directed extremes and register clamps,
// then runs random bursts under several window lengths.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cppt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int S_DEPTH  = SHORT_DEPTH_DEF;
  localparam int P_DEPTH  = PEP_DEPTH_DEF;
  localparam int L_DEPTH  = LONG_DEPTH_DEF;
  localparam int AS_DEPTH = AVG_SHORT_DEPTH_DEF;
  localparam int AL_DEPTH = AVG_LONG_DEPTH_DEF;

  typedef struct {
    logic signed [15:0] peak;
    logic signed [15:0] pep;
    logic signed [15:0] longmax;
    logic [31:0]        avg_short;
    logic [31:0]        avg_long;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [31:0]           in_power_uw = '0;
  logic signed [15:0]    in_power_cdb = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic signed [15:0]    out_peak_cdb;
  logic signed [15:0]    out_pep_cdb;
  logic signed [15:0]    out_long_cdb;
  logic [31:0]           out_avg_short_uw;
  logic [31:0]           out_avg_long_uw;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_PEP_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state.
  logic [PEP_LEN_W-1:0]  pep_len_reg;
  logic [LONG_LEN_W-1:0] long_len_reg;
  logic signed [15:0]    short_cdb [64];
  logic signed [15:0]    pep_peaks [64];
  logic signed [15:0]    long_peps [64];
  int                    short_slot, pep_slot, long_slot;
  logic signed [15:0]    pep_level, long_level;
  logic [31:0]           short_uw [AS_DEPTH];
  logic [31:0]           long_uw [AL_DEPTH];
  longint unsigned       short_uw_sum, long_uw_sum;
  int                    short_uw_slot, long_uw_slot;

  reading_t expected_readings[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       pop_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cascaded_peak_pep_average_tracker_unit uut (.*);

  // Maximum over the first n entries of a ring.
  function automatic logic signed [15:0] ring_max(input logic signed [15:0] vals [64],
                                                  input int n);
    int best;
    best = -32'sh7fffffff;
    for (int i = 0; i < n; i++)
      if (int'(vals[i]) > best) best = vals[i];
    return best[15:0];
  endfunction

  function automatic int clamp_length(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_meter();
    pep_len_reg  = PEP_LEN_RST;
    long_len_reg = LONG_LEN_RST;
    foreach (short_cdb[i]) short_cdb[i] = '0;
    foreach (pep_peaks[i]) pep_peaks[i] = '0;
    foreach (long_peps[i]) long_peps[i] = '0;
    foreach (short_uw[i]) short_uw[i] = '0;
    foreach (long_uw[i]) long_uw[i] = '0;
    short_slot = 0; pep_slot = 0; long_slot = 0;
    pep_level = '0; long_level = '0;
    short_uw_sum = 0; long_uw_sum = 0;
    short_uw_slot = 0; long_uw_slot = 0;
  endtask

  // Advance the meter by one sample and return the reading it produces.
  function automatic reading_t meter_sample(input logic [31:0] uw,
                                            input logic signed [15:0] cdb);
    reading_t r;
    int plen, llen;
    bit pep_wrapped;
    plen = clamp_length(pep_len_reg, P_DEPTH);
    llen = clamp_length(long_len_reg, L_DEPTH);
    short_cdb[short_slot] = cdb;
    short_slot = (short_slot + 1) % S_DEPTH;
    r.peak = ring_max(short_cdb, S_DEPTH);
    // A full short window feeds the PEP ring, a full PEP window the long ring.
    if (short_slot == 0) begin
      pep_peaks[pep_slot] = r.peak;
      pep_slot++;
      pep_wrapped = pep_slot >= plen;
      if (pep_wrapped) pep_slot = 0;
      pep_level = ring_max(pep_peaks, plen);
      if (pep_level < r.peak) pep_level = r.peak;
      if (pep_wrapped) begin
        long_peps[long_slot] = pep_level;
        long_slot++;
        if (long_slot >= llen) long_slot = 0;
        long_level = ring_max(long_peps, llen);
      end
    end
    if (pep_level < r.peak) pep_level = r.peak;
    if (long_level < pep_level) long_level = pep_level;
    r.pep = pep_level;
    r.longmax = long_level;
    // Moving sums over the newest depth - 1 samples.
    short_uw[short_uw_slot] = uw;
    short_uw_sum += uw;
    short_uw_slot = (short_uw_slot + 1) % AS_DEPTH;
    short_uw_sum -= short_uw[short_uw_slot];
    r.avg_short = 32'(short_uw_sum / (AS_DEPTH - 1));
    long_uw[long_uw_slot] = uw;
    long_uw_sum += uw;
    long_uw_slot = (long_uw_slot + 1) % AL_DEPTH;
    long_uw_sum -= long_uw[long_uw_slot];
    r.avg_long = 32'(long_uw_sum / (AL_DEPTH - 1));
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  // Send one request and hold it until the block takes it.
  task automatic send_sample(input logic [31:0] uw, input logic signed [15:0] cdb);
    @(negedge clk);
    in_push      = 1'b1;
    in_power_uw  = uw;
    in_power_cdb = cdb;
    do @(posedge clk); while (in_full);
    expected_readings.push_back(meter_sample(uw, cdb));
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_push = 1'b0;
    end
  endtask

  // Let every reading come back and the sequencer go quiet.
  task automatic drain();
    pause_sender(1);
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DATA_W'(value);
    if (idx == REG_PEP_LENGTH) pep_len_reg = PEP_LEN_W'(value);
    else long_len_reg = LONG_LEN_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [15:0] random_cdb();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 200)) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_uw();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd4000000000;
      default: return $urandom_range(0, 32'd4000000000);
    endcase
  endfunction

  // Random bursts with random gaps; some stretches run without gaps.
  task automatic send_random(input int count);
    int burst;
    bit no_gaps;
    burst = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        burst = $urandom_range(1, 12);
        if (!no_gaps) pause_sender($urandom_range(0, 6));
      end
      send_sample(random_uw(), random_cdb());
      burst--;
    end
  endtask

  task automatic test_field_extremes();
    send_sample(32'd0, 16'sh8000);
    send_sample(32'd4000000000, 16'sh7fff);
    send_sample(32'hffff_ffff, 16'sh0000);
    send_sample(32'h5555_5555, 16'sh5555);
    send_sample(32'haaaa_aaaa, 16'shaaaa);
    send_sample(32'd1, -16'sd1);
    for (int i = 0; i < 14; i++) send_sample(32'd4000000000, 16'sh8000);
  endtask

  task automatic test_register_clamps();
    write_reg(REG_PEP_LENGTH, 0);
    write_reg(REG_LONG_LENGTH, 0);
    send_random(40);
    write_reg(REG_PEP_LENGTH, 127);
    write_reg(REG_LONG_LENGTH, 63);
    send_random(40);
    write_reg(REG_PEP_LENGTH, 64);
    write_reg(REG_LONG_LENGTH, 32);
    send_random(200);
    write_reg(REG_PEP_LENGTH, 1);
    write_reg(REG_LONG_LENGTH, 1);
    send_random(40);
  endtask

  // Shrink a window below its current write position.
  task automatic test_length_shrink();
    write_reg(REG_PEP_LENGTH, 6);
    write_reg(REG_LONG_LENGTH, 5);
    send_random(16 * 6 * 3 + 16 * 4);
    write_reg(REG_PEP_LENGTH, 2);
    write_reg(REG_LONG_LENGTH, 2);
    send_random(100);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_PEP_LENGTH, $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 6));
      write_reg(REG_LONG_LENGTH, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                           : $urandom_range(1, 8));
      send_random(120);
    end
  endtask

  // Receiver stalls: switch between never, sometimes and mostly stalling.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) pop_mode = $urandom_range(0, 2);
    case (pop_mode)
      0: out_pop = 1'b1;
      1: out_pop = ($urandom_range(0, 2) != 0);
      default: out_pop = ($urandom_range(0, 5) == 0);
    endcase
  end

  // Compare each returned reading with the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && !out_empty && out_pop) begin
      if (expected_readings.size() == 0) begin
        $display("unexpected reading returned");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_peak_cdb !== want.peak) report_mismatch("peak_cdb", out_peak_cdb, want.peak);
        if (out_pep_cdb !== want.pep) report_mismatch("pep_cdb", out_pep_cdb, want.pep);
        if (out_long_cdb !== want.longmax)
          report_mismatch("long_cdb", out_long_cdb, want.longmax);
        if (out_avg_short_uw !== want.avg_short)
          report_mismatch("avg_short_uw", out_avg_short_uw, want.avg_short);
        if (out_avg_long_uw !== want.avg_long)
          report_mismatch("avg_long_uw", out_avg_long_uw, want.avg_long);
      end
    end
  end

  // Watchdog on cycles where neither side moves a request.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (!out_empty && out_pop)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_meter();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_field_extremes();
    test_register_clamps();
    test_length_shrink();
    test_random_traffic();
    drain();
    if (expected_readings.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cppt_pkg.sv
hdl/cppt_fifo.sv
hdl/cppt_front.sv
hdl/cppt_div.sv
hdl/cppt_back.sv
hdl/cascaded_peak_pep_average_tracker_unit.sv
hdl/cppt_checker.sv
tb/testbench.sv
